// ----- sv/rrt_pkg.sv -----
// ----------------------------------------------------------------------------
// rrt_pkg
// Types, codes and sizes shared by the retry timeout table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rrt_pkg;

   localparam int SLOTS       = 16;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int TIME_W      = 32;
   localparam int ATT_W       = 8;
   localparam int ENTRY_W     = TIME_W + ATT_W;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [1:0] FUNC_NEW  = 2'd0;
   localparam logic [1:0] FUNC_RSP  = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   localparam logic [1:0] EV_TRANSMIT = 2'd0;
   localparam logic [1:0] EV_DONE     = 2'd1;
   localparam logic [1:0] EV_TIMEOUT  = 2'd2;
   localparam logic [1:0] EV_REJECT   = 2'd3;

   localparam logic REG_MAX_ATTEMPTS = 1'b0;
   localparam logic REG_TIMEOUT      = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic scan_hit;
      logic idx_inc;
      logic flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic in_tick;
      logic ctx_unknown;
      logic expired;
      logic out_free;
      logic have_held;
      logic scan_done;
      logic cap_hit;
   } ctrl_sts_type;

endpackage

`default_nettype wire

// ----- sv/request_retry_timeout_table.sv -----
// ----------------------------------------------------------------------------
// request_retry_timeout_table
// Retransmission timer table with a retry limit, one slot per request id.
// ----------------------------------------------------------------------------
// A new-request or response item is accepted in the idle state; in the execute
// state it updates its slot and loads the result register, waiting there if the
// result channel stalls. A tick item scans the slots in order through the
// single read port of the slot RAM, with a read state and an evaluate state per
// slot, and waits on any result channel stall. During a scan one result is
// held back so that the last one of the tick can be marked; the scan stops
// early once MAX_RESULTS events have been produced. Input transfers are taken
// only when the previous item is finished. The slot RAM needs no clearing.
`default_nettype none

module request_retry_timeout_table import rrt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_func,
   input  wire logic [7:0]            req_req_id,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_event_kind,
   output logic [7:0]                 rsp_slot_id,
   output logic [7:0]                 rsp_attempt_number,
   output logic                       rsp_last,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   rrt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   rrt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_req_id        (req_req_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_slot_id       (rsp_slot_id),
      .rsp_attempt_number(rsp_attempt_number),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

endmodule

`default_nettype wire

// ----- sv/rrt_ram.sv -----
// ----------------------------------------------------------------------------
// rrt_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/rrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrt_ctrl
// Sequencer for item execution, the tick scan and the final result flush.
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_ctrl import rrt_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire ctrl_sts_type sts,
   output ctrl_cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.in_tick ? ST_SCAN_RD : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.ctx_unknown) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            if (sts.expired) begin
               if (!sts.have_held || sts.out_free) begin
                  cmd.scan_hit = 1'b1;
                  if (sts.scan_done || sts.cap_hit) begin
                     state_in = ST_FLUSH;
                  end else begin
                     cmd.idx_inc = 1'b1;
                     state_in    = ST_SCAN_RD;
                  end
               end
            end else if (sts.scan_done) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_FLUSH: begin
            if (!sts.have_held) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == ST_EXEC || state_ff == ST_SCAN_RD))
      else $error("accepted item did not start execution");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_hit || cmd.idx_inc) |-> state_ff == ST_SCAN_EV)
      else $error("scan command outside scan evaluation");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.exec, cmd.scan_hit, cmd.flush}))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ----- sv/rrt_dp.sv -----
// ----------------------------------------------------------------------------
// rrt_dp
// Slot table, time counter, configuration registers and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_dp import rrt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   output ctrl_sts_type               sts,
   input  wire logic [1:0]            req_func,
   input  wire logic [7:0]            req_req_id,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_event_kind,
   output logic [7:0]                 rsp_slot_id,
   output logic [7:0]                 rsp_attempt_number,
   output logic                       rsp_last,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [ATT_W-1:0]  max_att_ff;
   logic [15:0]       timeout_ff;
   logic [TIME_W-1:0] now_ff;
   logic [SLOTS-1:0]  active_ff;
   logic [1:0]        func_ff;
   logic [7:0]        id_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              have_held_ff;
   logic [1:0]        held_kind_ff;
   logic [7:0]        held_id_ff;
   logic [7:0]        held_att_ff;
   logic              out_valid_ff;
   logic [1:0]        out_kind_ff;
   logic [7:0]        out_id_ff;
   logic [7:0]        out_att_ff;
   logic              out_last_ff;

   logic              csr_wr;
   logic              id_ok;
   logic [SLOT_W-1:0] id_slot;
   logic [TIME_W-1:0] deadline_new;
   logic [ENTRY_W-1:0] rd_entry;
   logic [TIME_W-1:0] rd_deadline;
   logic [ATT_W-1:0]  rd_att;
   logic [TIME_W-1:0] diff;
   logic              retrans;
   logic [ATT_W-1:0]  att_next;
   logic [1:0]        exec_kind;
   logic [7:0]        exec_att;
   logic [1:0]        scan_kind;
   logic [7:0]        scan_att;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic              out_free;
   logic              push;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_ff}
                                                     : {24'd0, max_att_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         max_att_ff <= 8'd3;
         timeout_ff <= 16'd5;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_TIMEOUT) begin
            timeout_ff <= csr_pwdata[15:0];
         end else begin
            max_att_ff <= csr_pwdata[7:0];
         end
      end
   end

   assign id_ok        = id_ff < 8'(SLOTS);
   assign id_slot      = id_ff[SLOT_W-1:0];
   assign deadline_new = now_ff + {16'd0, timeout_ff};
   assign rd_deadline  = rd_entry[ENTRY_W-1:ATT_W];
   assign rd_att       = rd_entry[ATT_W-1:0];
   assign diff         = now_ff - rd_deadline;
   assign retrans      = rd_att < max_att_ff;
   assign att_next     = rd_att + 8'd1;

   assign exec_kind = !id_ok ? EV_REJECT : (func_ff == FUNC_NEW) ? EV_TRANSMIT : EV_DONE;
   assign exec_att  = (id_ok && func_ff == FUNC_NEW) ? 8'd1 : 8'd0;
   assign scan_kind = retrans ? EV_TRANSMIT : EV_TIMEOUT;
   assign scan_att  = retrans ? att_next : 8'd0;

   assign wr_en   = (cmd.exec && id_ok && func_ff == FUNC_NEW) || (cmd.scan_hit && retrans);
   assign wr_addr = cmd.exec ? id_slot : idx_ff;
   assign wr_data = {deadline_new, cmd.exec ? 8'd1 : att_next};

   rrt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_ff),
      .rd_data(rd_entry)
   );

   assign out_free = !out_valid_ff || rsp_ready;
   assign push     = cmd.exec || (cmd.scan_hit && have_held_ff) || cmd.flush;

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         active_ff    <= '0;
         have_held_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         if (cmd.accept) begin
            if (req_func == FUNC_TICK) begin
               now_ff <= now_ff + 32'd1;
            end
            idx_ff       <= '0;
            cnt_ff       <= '0;
            have_held_ff <= 1'b0;
         end
         if (cmd.exec && id_ok) begin
            active_ff[id_slot] <= (func_ff == FUNC_NEW);
         end
         if (cmd.scan_hit) begin
            if (!retrans) begin
               active_ff[idx_ff] <= 1'b0;
            end
            cnt_ff       <= cnt_ff + CNT_W'(1);
            have_held_ff <= 1'b1;
         end
         if (cmd.idx_inc) begin
            idx_ff <= idx_ff + SLOT_W'(1);
         end
         if (cmd.flush) begin
            have_held_ff <= 1'b0;
         end
         if (push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         id_ff   <= req_req_id;
      end
      if (cmd.scan_hit) begin
         held_kind_ff <= scan_kind;
         held_id_ff   <= 8'(idx_ff);
         held_att_ff  <= scan_att;
      end
      if (cmd.exec) begin
         out_kind_ff <= exec_kind;
         out_id_ff   <= id_ff;
         out_att_ff  <= exec_att;
         out_last_ff <= 1'b1;
      end else if (push) begin
         out_kind_ff <= held_kind_ff;
         out_id_ff   <= held_id_ff;
         out_att_ff  <= held_att_ff;
         out_last_ff <= cmd.flush;
      end
   end

   assign sts.in_tick     = req_func == FUNC_TICK;
   assign sts.ctx_unknown = func_ff == FUNC_NONE;
   assign sts.expired     = active_ff[idx_ff] && (diff != '0) && !diff[TIME_W-1];
   assign sts.out_free    = out_free;
   assign sts.have_held   = have_held_ff;
   assign sts.scan_done   = idx_ff == SLOT_W'(SLOTS - 1);
   assign sts.cap_hit     = cnt_ff == CNT_W'(MAX_RESULTS - 1);

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_kind     = out_kind_ff;
   assign rsp_slot_id        = out_id_ff;
   assign rsp_attempt_number = out_att_ff;
   assign rsp_last           = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result overwritten before transfer");

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("tick result count beyond cap");

   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_hit |-> sts.expired)
      else $error("slot handled without expiry");

   assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !have_held_ff)
      else $error("held result kept after flush");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the retry timeout table: a local table predicts the
// events of every accepted item and each result transfer is compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import rrt_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 3 * SLOTS + 10;
   localparam int RANDOM_ITEMS = 290;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] slot;
      logic [7:0] attempt;
      logic       last;
   } timer_event_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_func = FUNC_NONE;
   logic [7:0]            req_req_id = 8'd0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_event_kind;
   logic [7:0]            rsp_slot_id;
   logic [7:0]            rsp_attempt_number;
   logic                  rsp_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = 32'd0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   logic [7:0]  cfg_max_attempts = 8'd3;
   logic [15:0] cfg_timeout = 16'd5;
   logic [31:0] tbl_now = 32'd0;
   logic        tbl_active [SLOTS];
   logic [31:0] tbl_deadline [SLOTS];
   logic [7:0]  tbl_attempts [SLOTS];

   timer_event_type due_events [$];
   logic            gaps_on = 1'b0;
   int              failures = 0;
   int              results_checked = 0;
   int              items_sent = 0;
   int              register_writes = 0;
   int              kind_seen [4] = '{0, 0, 0, 0};
   int              cycle_count = 0;
   int              stall_left = 0;

   request_retry_timeout_table DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_req_id         (req_req_id),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_slot_id        (rsp_slot_id),
      .rsp_attempt_number (rsp_attempt_number),
      .rsp_last           (rsp_last),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: done, errors");
         $finish;
      end
   end

   function automatic timer_event_type make_event(logic [1:0] kind, logic [7:0] slot,
                                                  logic [7:0] attempt);
      timer_event_type ev;
      ev.kind = kind;
      ev.slot = slot;
      ev.attempt = attempt;
      ev.last = 1'b0;
      return ev;
   endfunction

   task automatic table_update(input logic [1:0] func, input logic [7:0] id);
      timer_event_type batch [$];
      logic [31:0]     lag;
      int              s;
      if (func == FUNC_NEW || func == FUNC_RSP) begin
         if (id >= SLOTS) begin
            batch.push_back(make_event(EV_REJECT, id, 8'd0));
         end else if (func == FUNC_NEW) begin
            tbl_active[id] = 1'b1;
            tbl_attempts[id] = 8'd1;
            tbl_deadline[id] = tbl_now + cfg_timeout;
            batch.push_back(make_event(EV_TRANSMIT, id, 8'd1));
         end else begin
            tbl_active[id] = 1'b0;
            batch.push_back(make_event(EV_DONE, id, 8'd0));
         end
      end else if (func == FUNC_TICK) begin
         tbl_now = tbl_now + 32'd1;
         for (s = 0; s < SLOTS && batch.size() < MAX_RESULTS; s++) begin
            lag = tbl_now - tbl_deadline[s];
            if (tbl_active[s] && $signed(lag) > 0) begin
               if (tbl_attempts[s] < cfg_max_attempts) begin
                  tbl_attempts[s] = tbl_attempts[s] + 8'd1;
                  tbl_deadline[s] = tbl_now + cfg_timeout;
                  batch.push_back(make_event(EV_TRANSMIT, 8'(s), tbl_attempts[s]));
               end else begin
                  tbl_active[s] = 1'b0;
                  batch.push_back(make_event(EV_TIMEOUT, 8'(s), 8'd0));
               end
            end
         end
      end
      if (batch.size() > 0) begin
         batch[batch.size() - 1].last = 1'b1;
      end
      foreach (batch[k]) begin
         due_events.push_back(batch[k]);
      end
   endtask

   // Result transfers are checked here; rsp_ready stalls come in random bursts.
   always @(posedge clock) begin
      timer_event_type want;
      timer_event_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind = rsp_event_kind;
         got.slot = rsp_slot_id;
         got.attempt = rsp_attempt_number;
         got.last = rsp_last;
         results_checked++;
         if (due_events.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("tb: unexpected result kind %0d slot %0d attempt %0d last %0d",
                        got.kind, got.slot, got.attempt, got.last);
            end
         end else begin
            want = due_events.pop_front();
            kind_seen[want.kind]++;
            if (got !== want) begin
               failures++;
               if (failures <= 10) begin
                  $display("tb: result %0d expected kind %0d slot %0d attempt %0d last %0d",
                           results_checked, want.kind, want.slot, want.attempt, want.last);
                  $display("tb: result %0d actual   kind %0d slot %0d attempt %0d last %0d",
                           results_checked, got.kind, got.slot, got.attempt, got.last);
               end
            end
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic [1:0] func, input logic [7:0] id);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      @(posedge clock);
      req_valid <= 1'b1;
      req_func <= func;
      req_req_id <= id;
      do @(posedge clock); while (!req_ready);
      table_update(func, id);
      items_sent++;
      req_valid <= 1'b0;
   endtask

   task automatic wait_results;
      while (due_events.size() != 0) @(posedge clock);
   endtask

   task automatic program_register(input logic index, input logic [31:0] value);
      logic [31:0] readback;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == REG_MAX_ATTEMPTS) begin
         cfg_max_attempts = value[7:0];
      end else begin
         cfg_timeout = value[15:0];
      end
      register_writes++;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = (index == REG_MAX_ATTEMPTS) ? {24'd0, cfg_max_attempts}
                                             : {16'd0, cfg_timeout};
      if ((index == REG_MAX_ATTEMPTS && csr_prdata[7:0] != readback[7:0]) ||
          (index == REG_TIMEOUT && csr_prdata[15:0] != readback[15:0])) begin
         failures++;
         if (failures <= 10) begin
            $display("tb: register %0d read expected %0h, got %0h",
                     index, readback, csr_prdata);
         end
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Only reconfigure once the table has gone quiet, including a silent scan.
   task automatic set_config(input logic [7:0] max_attempts, input logic [15:0] timeout);
      wait_results();
      repeat (SETTLE) @(posedge clock);
      program_register(REG_MAX_ATTEMPTS, {24'd0, max_attempts});
      program_register(REG_TIMEOUT, {16'd0, timeout});
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_reset_config;
      send_item(FUNC_NEW, 8'd0);
      send_item(FUNC_NEW, 8'(SLOTS - 1));
      send_item(FUNC_NEW, 8'(SLOTS));
      send_item(FUNC_NEW, 8'd255);
      send_item(FUNC_RSP, 8'd255);
      send_item(FUNC_RSP, 8'd7);
      send_item(FUNC_NONE, 8'hAA);
      send_ticks(1);
      send_item(FUNC_NEW, 8'd0);
      send_ticks(6);
      send_item(FUNC_RSP, 8'(SLOTS - 1));
      send_ticks(14);
   endtask

   task automatic test_attempt_limits;
      set_config(8'd0, 16'd1);
      send_item(FUNC_NEW, 8'd3);
      send_item(FUNC_NEW, 8'd9);
      send_ticks(3);
      set_config(8'd1, 16'd1);
      send_item(FUNC_NEW, 8'd4);
      send_item(FUNC_NEW, 8'd5);
      send_item(FUNC_RSP, 8'd4);
      send_ticks(3);
   endtask

   task automatic test_full_table_expiry;
      set_config(8'd2, 16'd2);
      for (int s = 0; s < SLOTS; s++) begin
         send_item(FUNC_NEW, 8'(s));
      end
      send_ticks(7);
   endtask

   task automatic test_register_extremes;
      set_config(8'd255, 16'd65535);
      send_item(FUNC_NEW, 8'd1);
      send_item(FUNC_NEW, 8'd2);
      send_ticks(3);
      send_item(FUNC_RSP, 8'd1);
      send_item(FUNC_RSP, 8'd2);
      set_config(8'd255, 16'd1);
      send_item(FUNC_NEW, 8'd6);
      send_ticks(5);
   endtask

   task automatic test_random_traffic;
      int          phase_items;
      int          r;
      logic [1:0]  func;
      logic [7:0]  id;
      for (int phase = 0; phase < 5; phase++) begin
         r = $urandom_range(0, 9);
         set_config((r == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 4)),
                    (r == 1) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 8)));
         gaps_on = (phase == 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / 5) begin
            r = $urandom_range(0, 99);
            id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(SLOTS, 255))
                                             : 8'($urandom_range(0, SLOTS - 1));
            if (r < 40) begin
               func = FUNC_NEW;
            end else if (r < 62) begin
               func = FUNC_RSP;
            end else if (r < 95) begin
               func = FUNC_TICK;
            end else begin
               func = FUNC_NONE;
            end
            if (phase == 1 && phase_items == 10) begin
               wait_results();
            end else if ($urandom_range(0, 39) == 0) begin
               wait_results();
            end
            send_item(func, id);
            if (func != FUNC_NONE) begin
               phase_items++;
            end
         end
      end
   endtask

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         tbl_active[s] = 1'b0;
         tbl_deadline[s] = 32'd0;
         tbl_attempts[s] = 8'd0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      gaps_on = 1'b1;
      test_reset_config();
      test_attempt_limits();
      test_full_table_expiry();
      test_register_extremes();
      test_random_traffic();
      wait_results();
      repeat (SETTLE) @(posedge clock);
      failures += due_events.size();
      $display("tb: %0d items, %0d results checked, %0d register writes",
               items_sent, results_checked, register_writes);
      $display("tb: transmits %0d, completions %0d, final timeouts %0d, rejects %0d",
               kind_seen[EV_TRANSMIT], kind_seen[EV_DONE], kind_seen[EV_TIMEOUT],
               kind_seen[EV_REJECT]);
      if (failures == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
